// ===== hdl/evnb_pkg.sv =====
`default_nettype none
package evnb_pkg;
    localparam int NUM_CH    = 64;
    localparam int CH_BITS   = 6;
    localparam int IDX_BITS  = 24;
    localparam int TIME_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int SUMT_BITS = 40;
    localparam int SUMC_BITS = 14;
    localparam int MEAN_BITS = TIME_BITS + 1;
    localparam int DIV_DW    = MEAN_BITS + FRAC_BITS;
    localparam int DIV_VW    = 32;

    localparam logic [2:0] REG_NCH  = 3'd0;
    localparam logic [2:0] REG_RAD  = 3'd1;
    localparam logic [2:0] REG_STEP = 3'd2;
    localparam logic [2:0] REG_TRAD = 3'd3;
    localparam logic [2:0] REG_TWIN = 3'd4;
    localparam logic [2:0] REG_MODE = 3'd5;

    localparam logic [1:0] MODE_LOCAL  = 2'd1;
    localparam logic [1:0] MODE_GLOBAL = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quot;
        logic [DIV_VW-1:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== hdl/evnb_div.sv =====
`default_nettype none
module evnb_div (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  evnb_pkg::t_div_req i_req,
    output evnb_pkg::t_div_rsp o_rsp
);
    import evnb_pkg::*;

    localparam int CNT_W = $clog2(DIV_DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_DW-1:0] r_q;
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_VW-1:0] r_div;
    logic [DIV_VW:0]   shifted;
    logic              take;

    assign shifted = {r_rem, r_q[DIV_DW-1]};
    assign take    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_DW);
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                // one quotient bit per cycle, restoring
                r_q   <= {r_q[DIV_DW-2:0], take};
                r_rem <= take ? DIV_VW'(shifted - {1'b0, r_div}) : shifted[DIV_VW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;
endmodule
`default_nettype wire

// ===== hdl/event_neighbour_edge_builder.sv =====
// Edge builder for a stream of channel events. Each accepted event word gives a
// self-loop edge and then one edge to the latest remembered event on each
// examined neighbour channel within the time radius; the last edge carries
// is_last and, in local or global mode, the Q16.16 feature. One event at a
// time: the neighbour scan steps past skipped channels and checks each
// examined channel after a registered table read, and it stalls on each edge the
// output side does not take; the feature then needs up to four passes of a
// shared bit-serial divider, each with start and hand-back, and a pass with a
// zero dividend or divisor is skipped.
// o_ready is low from the accepted event until its last edge is loaded into
// the output register. The channel table needs no clearing pass after reset.
`default_nettype none
module event_neighbour_edge_builder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire logic [evnb_pkg::TIME_BITS-1:0] i_event_time,
    input  wire logic [evnb_pkg::CH_BITS-1:0]   i_event_channel,
    input  wire logic i_new_sequence,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic [evnb_pkg::IDX_BITS-1:0] o_source_index,
    output logic [evnb_pkg::IDX_BITS-1:0] o_target_index,
    output logic      o_is_last,
    output logic      o_feature_valid,
    output logic signed [31:0] o_feature_time,
    output logic signed [31:0] o_feature_channel,
    output logic      o_channel_error,
    output logic      o_index_saturated,
    input  wire logic i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    import evnb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_CHK    = 3'd2;
    localparam logic [2:0] S_FSTART = 3'd3;
    localparam logic [2:0] S_FWAIT  = 3'd4;
    localparam logic [2:0] S_LAST   = 3'd5;

    logic [2:0] r_state;

    logic [6:0]  r_cfg_nch;
    logic [4:0]  r_cfg_rad;
    logic [5:0]  r_cfg_step;
    logic [31:0] r_cfg_trad;
    logic [31:0] r_cfg_twin;
    logic [1:0]  r_cfg_mode;

    logic [TIME_BITS-1:0] mem_t [NUM_CH];
    logic [IDX_BITS-1:0]  mem_i [NUM_CH];
    logic [TIME_BITS-1:0] r_rd_t;
    logic [IDX_BITS-1:0]  r_rd_i;
    logic [NUM_CH-1:0]    r_tab_valid;
    logic [IDX_BITS-1:0]  r_ev_cnt;

    logic [TIME_BITS-1:0] r_t;
    logic [CH_BITS-1:0]   r_ch;
    logic [IDX_BITS-1:0]  r_idx;
    logic                 r_err;
    logic                 r_sat;
    logic signed [8:0]    r_n;
    logic signed [8:0]    r_nend;
    logic [IDX_BITS-1:0]  r_pend;
    logic signed [SUMT_BITS-1:0] r_sum_t;
    logic signed [SUMC_BITS-1:0] r_sum_c;
    logic [6:0]           r_ecnt;
    logic [1:0]           r_ph;
    logic [MEAN_BITS-1:0] r_mag_t;
    logic [MEAN_BITS-1:0] r_mag_c;
    logic [31:0]          r_ft;
    logic [31:0]          r_fc;

    logic                 r_ov;
    logic [IDX_BITS-1:0]  r_o_src;
    logic [IDX_BITS-1:0]  r_o_tgt;
    logic                 r_o_last;
    logic                 r_o_fv;
    logic [31:0]          r_o_ft;
    logic [31:0]          r_o_fc;
    logic                 r_o_err;
    logic                 r_o_sat;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [6:0]  lim;
    logic [5:0]  stp;
    logic        fvalid;
    logic        is_local;
    logic        in_acc;
    logic        out_free;
    logic        out_load;
    logic [IDX_BITS-1:0] idx_new;
    logic        cand;
    logic signed [TIME_BITS:0] d;
    logic        edge_ok;
    logic        neg_t;
    logic        neg_c;
    logic [SUMT_BITS-1:0] sum_mag_t;
    logic [SUMC_BITS-1:0] sum_mag_c;
    logic        ph_neg;
    logic [MEAN_BITS-1:0] ph_mag;
    logic [DIV_VW-1:0]    fix_div;
    logic [DIV_DW:0]      total;
    logic [DIV_DW:0]      sat_lim;
    logic [31:0]          clipped;
    logic [31:0]          fixed;

    assign lim      = (r_cfg_nch > 7'(NUM_CH)) ? 7'(NUM_CH) : r_cfg_nch;
    assign stp      = (r_cfg_step == '0) ? 6'd1 : r_cfg_step;
    assign fvalid   = (r_cfg_mode == MODE_LOCAL) || (r_cfg_mode == MODE_GLOBAL);
    assign is_local = r_cfg_mode == MODE_LOCAL;
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ov || i_ready;
    assign idx_new  = i_new_sequence ? '0 : r_ev_cnt;

    assign cand = !r_n[8] && (r_n < $signed({2'b00, lim})) && r_tab_valid[r_n[CH_BITS-1:0]];
    assign d       = $signed({1'b0, r_t}) - $signed({1'b0, r_rd_t});
    assign edge_ok = d <= $signed({1'b0, r_cfg_trad});

    // a word goes into the output register on this edge
    assign out_load = out_free && (((r_state == S_CHK) && edge_ok) || (r_state == S_LAST));

    assign neg_t     = r_sum_t[SUMT_BITS-1];
    assign neg_c     = r_sum_c[SUMC_BITS-1];
    assign sum_mag_t = neg_t ? SUMT_BITS'(-r_sum_t) : SUMT_BITS'(r_sum_t);
    assign sum_mag_c = neg_c ? SUMC_BITS'(-r_sum_c) : SUMC_BITS'(r_sum_c);

    assign ph_neg  = r_ph[0] ? neg_c : neg_t;
    assign ph_mag  = r_ph[0] ? r_mag_c : r_mag_t;
    always_comb begin
        if (r_ph[0])
            fix_div = is_local ? DIV_VW'(r_cfg_rad) : DIV_VW'(lim);
        else
            fix_div = is_local ? r_cfg_trad : r_cfg_twin;
    end
    assign sat_lim = ph_neg ? (DIV_DW+1)'(32'h8000_0000) : (DIV_DW+1)'(32'h7FFF_FFFF);
    // round half up on the remainder
    assign total   = {1'b0, div_rsp.quot}
                   + (DIV_DW+1)'({div_rsp.rem, 1'b0} >= {1'b0, fix_div});
    assign clipped = (total > sat_lim) ? sat_lim[31:0] : total[31:0];
    assign fixed   = ph_neg ? -clipped : clipped;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        if (r_state == S_FSTART) begin
            if (!r_ph[1]) begin
                div_req.start = r_ecnt != '0;
                div_req.divisor = DIV_VW'({r_ecnt, 1'b0});
                if (r_ph[0])
                    div_req.dividend = DIV_DW'({sum_mag_c, 1'b0}) + DIV_DW'(r_ecnt);
                else
                    div_req.dividend = DIV_DW'({sum_mag_t, 1'b0}) + DIV_DW'(r_ecnt);
            end else begin
                div_req.start    = (ph_mag != '0) && (fix_div != '0);
                div_req.dividend = {ph_mag, {FRAC_BITS{1'b0}}};
                div_req.divisor  = fix_div;
            end
        end
    end

    evnb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        r_rd_t <= mem_t[r_n[CH_BITS-1:0]];
        r_rd_i <= mem_i[r_n[CH_BITS-1:0]];
        if (r_state == S_LAST && out_free && !r_err) begin
            mem_t[r_ch] <= r_t;
            mem_i[r_ch] <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ov        <= 1'b0;
            r_tab_valid <= '0;
            r_ev_cnt    <= '0;
            r_cfg_nch   <= 7'd64;
            r_cfg_rad   <= 5'd2;
            r_cfg_step  <= 6'd1;
            r_cfg_trad  <= 32'd1000;
            r_cfg_twin  <= 32'd1000000;
            r_cfg_mode  <= MODE_LOCAL;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NCH:  r_cfg_nch  <= i_cfg_data[6:0];
                    REG_RAD:  r_cfg_rad  <= i_cfg_data[4:0];
                    REG_STEP: r_cfg_step <= i_cfg_data[5:0];
                    REG_TRAD: r_cfg_trad <= i_cfg_data;
                    REG_TWIN: r_cfg_twin <= i_cfg_data;
                    REG_MODE: r_cfg_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (out_load)
                r_ov <= 1'b1;
            else if (i_ready)
                r_ov <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_new_sequence)
                            r_tab_valid <= '0;
                        r_t     <= i_event_time;
                        r_ch    <= i_event_channel;
                        r_idx   <= idx_new;
                        r_pend  <= idx_new;
                        r_sat   <= idx_new == {IDX_BITS{1'b1}};
                        r_err   <= {1'b0, i_event_channel} >= lim;
                        r_ev_cnt <= idx_new;
                        r_n     <= $signed({3'b000, i_event_channel}) - $signed({4'b0000, r_cfg_rad});
                        r_nend  <= $signed({3'b000, i_event_channel}) + $signed({4'b0000, r_cfg_rad});
                        r_sum_t <= '0;
                        r_sum_c <= '0;
                        r_ecnt  <= '0;
                        r_ph    <= '0;
                        r_ft    <= '0;
                        r_fc    <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_n > r_nend)
                        r_state <= fvalid ? S_FSTART : S_LAST;
                    else if (cand)
                        r_state <= S_CHK;
                    else
                        r_n <= r_n + $signed({3'b000, stp});
                end
                S_CHK: begin
                    if (!edge_ok) begin
                        r_n     <= r_n + $signed({3'b000, stp});
                        r_state <= S_SCAN;
                    end else if (out_free) begin
                        // the held edge is not the last one
                        r_o_src  <= r_idx;
                        r_o_tgt  <= r_pend;
                        r_o_last <= 1'b0;
                        r_o_fv   <= 1'b0;
                        r_o_ft   <= '0;
                        r_o_fc   <= '0;
                        r_o_err  <= r_err;
                        r_o_sat  <= r_sat;
                        r_pend   <= r_rd_i;
                        r_ecnt   <= r_ecnt + 1'b1;
                        if (is_local) begin
                            r_sum_t <= r_sum_t + SUMT_BITS'(d);
                            r_sum_c <= r_sum_c + SUMC_BITS'($signed({3'b000, r_ch}) - r_n);
                        end else begin
                            r_sum_t <= r_sum_t + $signed(SUMT_BITS'(r_rd_t));
                            r_sum_c <= r_sum_c + SUMC_BITS'(r_n);
                        end
                        r_n     <= r_n + $signed({3'b000, stp});
                        r_state <= S_SCAN;
                    end
                end
                S_FSTART: begin
                    if (div_req.start) begin
                        r_state <= S_FWAIT;
                    end else begin
                        case (r_ph)
                            2'd0: r_mag_t <= '0;
                            2'd1: r_mag_c <= '0;
                            2'd2: r_ft <= (r_mag_t == '0) ? 32'd0 :
                                          (neg_t ? 32'h8000_0000 : 32'h7FFF_FFFF);
                            default: r_fc <= (r_mag_c == '0) ? 32'd0 :
                                          (neg_c ? 32'h8000_0000 : 32'h7FFF_FFFF);
                        endcase
                        r_ph <= r_ph + 1'b1;
                        if (r_ph == 2'd3)
                            r_state <= S_LAST;
                    end
                end
                S_FWAIT: begin
                    if (div_rsp.done) begin
                        case (r_ph)
                            2'd0: r_mag_t <= div_rsp.quot[MEAN_BITS-1:0];
                            2'd1: r_mag_c <= div_rsp.quot[MEAN_BITS-1:0];
                            2'd2: r_ft <= fixed;
                            default: r_fc <= fixed;
                        endcase
                        r_ph    <= r_ph + 1'b1;
                        r_state <= (r_ph == 2'd3) ? S_LAST : S_FSTART;
                    end
                end
                S_LAST: begin
                    if (out_free) begin
                        r_o_src  <= r_idx;
                        r_o_tgt  <= r_pend;
                        r_o_last <= 1'b1;
                        r_o_fv   <= fvalid;
                        r_o_ft   <= r_ft;
                        r_o_fc   <= r_fc;
                        r_o_err  <= r_err;
                        r_o_sat  <= r_sat;
                        if (!r_err)
                            r_tab_valid[r_ch] <= 1'b1;
                        if (!r_sat)
                            r_ev_cnt <= r_idx + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready           = r_state == S_IDLE;
    assign o_valid           = r_ov;
    assign o_source_index    = r_o_src;
    assign o_target_index    = r_o_tgt;
    assign o_is_last         = r_o_last;
    assign o_feature_valid   = r_o_fv;
    assign o_feature_time    = r_o_ft;
    assign o_feature_channel = r_o_fc;
    assign o_channel_error   = r_o_err;
    assign o_index_saturated = r_o_sat;
endmodule
`default_nettype wire

// ===== hdl/evnb_checker.sv =====
`default_nettype none
module evnb_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic [evnb_pkg::IDX_BITS-1:0] o_target_index,
    input wire logic o_is_last,
    input wire logic o_feature_valid,
    input wire logic [31:0] o_feature_time,
    input wire logic [31:0] o_feature_channel
);
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while previous event still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_target_index) && $stable(o_is_last))
        else $error("stalled output word changed");

    a_feature_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_feature_valid |-> o_is_last)
        else $error("feature on a word that is not last");

    a_feature_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_feature_valid |-> o_feature_time == 32'd0 && o_feature_channel == 32'd0)
        else $error("feature fields nonzero without feature_valid");
endmodule

bind event_neighbour_edge_builder evnb_checker u_evnb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_target_index    (o_target_index),
    .o_is_last         (o_is_last),
    .o_feature_valid   (o_feature_valid),
    .o_feature_time    (o_feature_time),
    .o_feature_channel (o_feature_channel)
);
`default_nettype wire
